// ===== hw/rtl/crm_pkg.sv =====
// Shared types and constants for the Catmull-Rom segment generator.
package crm_pkg;

   localparam int DEF_MAX_STEPS  = 16;
   localparam int DEF_COORD_BITS = 12;
   localparam int OUT_BITS       = 13;
   localparam int CFG_W          = 5;
   localparam int STEPS_RESET    = 16;
   localparam int RSP_W          = ((4 * OUT_BITS + 7) / 8) * 8;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_S2, ST_S3, ST_CS, ST_BS, ST_PS,
      ST_H0, ST_H1, ST_H2, ST_DINIT, ST_DSTEP, ST_STORE, ST_EMIT, ST_WIN
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_S2, OP_S3, OP_CS, OP_BS, OP_PS,
      OP_H0, OP_H1, OP_H2, OP_DINIT, OP_DSTEP, OP_STORE
   } dp_op_type;

   // Which window points form p0..p3 of a span (A,B,C = window, Q = new point)
   typedef enum logic [2:0] {
      SPAN_AAQQ, SPAN_AABQ, SPAN_ABQQ, SPAN_ABCQ, SPAN_BCQQ
   } span_kind_type;

   typedef enum logic [2:0] {
      WIN_NONE, WIN_SET0, WIN_SET1, WIN_SET2, WIN_SHIFT
   } win_op_type;

   typedef struct packed {
      dp_op_type     op;
      span_kind_type kind;
      win_op_type    win;
      logic          capture;
      logic          k_clear;
      logic          k_inc;
      logic          out_load;
      logic          out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic k_zero;
      logic k_end;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/crm_lane.sv =====
// One coordinate lane: span coefficients, Horner evaluation, divider, saturation.
module crm_lane #(
   parameter int MAX_STEPS  = crm_pkg::DEF_MAX_STEPS,
   parameter int COORD_BITS = crm_pkg::DEF_COORD_BITS,
   localparam int SB    = $clog2(MAX_STEPS + 1),
   localparam int CW    = COORD_BITS + 4,
   localparam int NUM_W = COORD_BITS + 3 * SB + 6,
   localparam int MB    = 3 * SB + 1,
   localparam int Q_W   = COORD_BITS + 3,
   localparam int DV_W  = 3 * SB + Q_W,
   localparam int CMP_W = (NUM_W > DV_W) ? NUM_W : DV_W,
   localparam int SAT_W = ((Q_W > crm_pkg::OUT_BITS) ? Q_W : crm_pkg::OUT_BITS) + 1
) (
   input  logic                              clock,
   input  crm_pkg::dp_cmd_type               cmd,
   input  logic signed [COORD_BITS-1:0]      w0,
   input  logic signed [COORD_BITS-1:0]      w1,
   input  logic signed [COORD_BITS-1:0]      w2,
   input  logic signed [COORD_BITS-1:0]      q,
   input  logic [SB-1:0]                     s_eff,
   input  logic [2*SB-1:0]                   s2,
   input  logic [3*SB-1:0]                   s3,
   input  logic [SB-1:0]                     k,
   output logic signed [crm_pkg::OUT_BITS-1:0] val
);

   logic signed [COORD_BITS-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [NUM_W-1:0]      cs_ff, bs_ff, ps_ff, acc_ff;
   logic [NUM_W-1:0]             rem_ff;
   logic [DV_W-1:0]              dv_ff;
   logic [Q_W-1:0]               quo_ff;
   logic                         neg_ff;

   logic signed [CW-1:0] pe0, pe1, pe2, pe3, cb, cc, cd, p1x2;
   logic signed [NUM_W-1:0] mul_a, addend, res;
   logic signed [MB-1:0] mul_b;
   logic signed [NUM_W+MB-1:0] prod;
   logic [NUM_W-1:0] acc_mag;
   logic [CMP_W-1:0] rem_c, dv_c, diff;
   logic fits;
   logic [SAT_W-1:0] quo_w, lim, mag;

   // Curve coefficients of the loaded span
   assign pe0  = {{4{p0_ff[COORD_BITS-1]}}, p0_ff};
   assign pe1  = {{4{p1_ff[COORD_BITS-1]}}, p1_ff};
   assign pe2  = {{4{p2_ff[COORD_BITS-1]}}, p2_ff};
   assign pe3  = {{4{p3_ff[COORD_BITS-1]}}, p3_ff};
   assign p1x2 = pe1 <<< 1;
   assign cb   = pe2 - pe0;
   assign cc   = (pe0 <<< 1) - ((pe1 <<< 2) + pe1) + (pe2 <<< 2) - pe3;
   assign cd   = ((pe1 <<< 1) + pe1) - ((pe2 <<< 1) + pe2) + pe3 - pe0;

   // Shared multiplier with accumulate
   always_comb begin
      mul_a  = {{(NUM_W-CW){cd[CW-1]}}, cd};
      mul_b  = {{(MB-SB){1'b0}}, k};
      addend = '0;
      case (cmd.op)
         crm_pkg::OP_CS: begin
            mul_a = {{(NUM_W-CW){cc[CW-1]}}, cc};
            mul_b = {{(MB-SB){1'b0}}, s_eff};
         end
         crm_pkg::OP_BS: begin
            mul_a = {{(NUM_W-CW){cb[CW-1]}}, cb};
            mul_b = {{(MB-2*SB){1'b0}}, s2};
         end
         crm_pkg::OP_PS: begin
            mul_a = {{(NUM_W-CW){p1x2[CW-1]}}, p1x2};
            mul_b = {1'b0, s3};
         end
         crm_pkg::OP_H0: addend = cs_ff;
         crm_pkg::OP_H1: begin
            mul_a  = acc_ff;
            addend = bs_ff;
         end
         crm_pkg::OP_H2: begin
            mul_a  = acc_ff;
            addend = ps_ff;
         end
         default: ;
      endcase
   end
   assign prod = mul_a * mul_b;
   assign res  = $signed(prod[NUM_W-1:0]) + addend;

   // Divider compare
   assign acc_mag = acc_ff[NUM_W-1] ? -acc_ff : acc_ff;
   assign rem_c   = CMP_W'(rem_ff);
   assign dv_c    = CMP_W'(dv_ff);
   assign fits    = rem_c >= dv_c;
   assign diff    = rem_c - dv_c;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         crm_pkg::OP_LOAD: begin
            p0_ff <= (cmd.kind == crm_pkg::SPAN_BCQQ) ? w1 : w0;
            unique case (cmd.kind)
               crm_pkg::SPAN_AAQQ, crm_pkg::SPAN_AABQ: p1_ff <= w0;
               crm_pkg::SPAN_ABQQ, crm_pkg::SPAN_ABCQ: p1_ff <= w1;
               default:                                p1_ff <= w2;
            endcase
            unique case (cmd.kind)
               crm_pkg::SPAN_AABQ: p2_ff <= w1;
               crm_pkg::SPAN_ABCQ: p2_ff <= w2;
               default:            p2_ff <= q;
            endcase
            p3_ff <= q;
         end
         crm_pkg::OP_CS: cs_ff <= res;
         crm_pkg::OP_BS: bs_ff <= res;
         crm_pkg::OP_PS: ps_ff <= res;
         crm_pkg::OP_H0, crm_pkg::OP_H1, crm_pkg::OP_H2: acc_ff <= res;
         crm_pkg::OP_DINIT: begin
            neg_ff <= acc_ff[NUM_W-1];
            rem_ff <= acc_mag;
            dv_ff  <= {s3, 1'b0, {(Q_W-1){1'b0}}};
            quo_ff <= '0;
         end
         crm_pkg::OP_DSTEP: begin
            if (fits) begin
               rem_ff <= diff[NUM_W-1:0];
            end
            quo_ff <= {quo_ff[Q_W-2:0], fits};
            dv_ff  <= dv_ff >> 1;
         end
         default: ;
      endcase
   end

   // Saturate magnitude and apply sign
   assign quo_w = SAT_W'(quo_ff);
   assign lim   = neg_ff ? SAT_W'(1 << (crm_pkg::OUT_BITS - 1))
                         : SAT_W'((1 << (crm_pkg::OUT_BITS - 1)) - 1);
   assign mag   = (quo_w > lim) ? lim : quo_w;
   assign val   = neg_ff ? -mag[crm_pkg::OUT_BITS-1:0] : mag[crm_pkg::OUT_BITS-1:0];

endmodule

// ===== hw/rtl/crm_datapath.sv =====
// Datapath: step register, point window, two lanes, counters and output register.
module crm_datapath #(
   parameter int MAX_STEPS  = crm_pkg::DEF_MAX_STEPS,
   parameter int COORD_BITS = crm_pkg::DEF_COORD_BITS,
   localparam int SB  = $clog2(MAX_STEPS + 1),
   localparam int Q_W = COORD_BITS + 3,
   localparam int DCW = $clog2(Q_W)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crm_pkg::dp_cmd_type               cmd,
   input  logic signed [COORD_BITS-1:0]      in_x,
   input  logic signed [COORD_BITS-1:0]      in_y,
   input  logic                              csr_valid,
   input  logic [crm_pkg::CFG_W-1:0]         csr_data,
   input  logic                              rsp_tready,
   output crm_pkg::dp_status_type            status,
   output logic                              rsp_valid,
   output logic signed [crm_pkg::OUT_BITS-1:0] seg_x1,
   output logic signed [crm_pkg::OUT_BITS-1:0] seg_y1,
   output logic signed [crm_pkg::OUT_BITS-1:0] seg_x2,
   output logic signed [crm_pkg::OUT_BITS-1:0] seg_y2,
   output logic                              last_of_run
);

   localparam int OB = crm_pkg::OUT_BITS;

   logic [crm_pkg::CFG_W-1:0]    steps_ff;
   logic [SB-1:0]                s_eff, k_ff;
   logic [2*SB-1:0]              s2_ff;
   logic [3*SB-1:0]              s3_ff;
   logic [DCW-1:0]               div_cnt_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic signed [COORD_BITS-1:0] wx_ff [3];
   logic signed [COORD_BITS-1:0] wy_ff [3];
   logic signed [OB-1:0]         prev_x_ff, prev_y_ff, cur_x_ff, cur_y_ff;
   logic signed [OB-1:0]         out_x1_ff, out_y1_ff, out_x2_ff, out_y2_ff;
   logic                         out_last_ff, out_valid_ff;
   logic signed [OB-1:0]         val_x, val_y;
   logic [2*SB-1:0]              s2_in;
   logic [3*SB-1:0]              s3_in;

   // Step count register, clamped to 1..MAX_STEPS for use
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= crm_pkg::CFG_W'(crm_pkg::STEPS_RESET);
      end else if (csr_valid) begin
         steps_ff <= csr_data;
      end
   end

   always_comb begin
      if (steps_ff == '0) begin
         s_eff = SB'(1);
      end else if (int'(steps_ff) > MAX_STEPS) begin
         s_eff = SB'(MAX_STEPS);
      end else begin
         s_eff = SB'(steps_ff);
      end
   end

   assign s2_in = s_eff * s_eff;
   assign s3_in = s2_ff * s_eff;

   // Powers of S, segment index and divide step counter
   always_ff @(posedge clock) begin
      if (cmd.op == crm_pkg::OP_S2) s2_ff <= s2_in;
      if (cmd.op == crm_pkg::OP_S3) s3_ff <= s3_in;
      if (cmd.k_clear) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + SB'(1);
      end
      if (cmd.op == crm_pkg::OP_DINIT) begin
         div_cnt_ff <= '0;
      end else if (cmd.op == crm_pkg::OP_DSTEP) begin
         div_cnt_ff <= div_cnt_ff + DCW'(1);
      end
   end

   // New point capture and window update
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qx_ff <= in_x;
         qy_ff <= in_y;
      end
      case (cmd.win)
         crm_pkg::WIN_SET0: begin
            wx_ff[0] <= qx_ff;
            wy_ff[0] <= qy_ff;
         end
         crm_pkg::WIN_SET1: begin
            wx_ff[1] <= qx_ff;
            wy_ff[1] <= qy_ff;
         end
         crm_pkg::WIN_SET2: begin
            wx_ff[2] <= qx_ff;
            wy_ff[2] <= qy_ff;
         end
         crm_pkg::WIN_SHIFT: begin
            wx_ff[0] <= wx_ff[1];
            wy_ff[0] <= wy_ff[1];
            wx_ff[1] <= wx_ff[2];
            wy_ff[1] <= wy_ff[2];
            wx_ff[2] <= qx_ff;
            wy_ff[2] <= qy_ff;
         end
         default: ;
      endcase
   end

   crm_lane #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_lane_x (
      .clock(clock), .cmd(cmd), .w0(wx_ff[0]), .w1(wx_ff[1]), .w2(wx_ff[2]),
      .q(qx_ff), .s_eff(s_eff), .s2(s2_ff), .s3(s3_ff), .k(k_ff), .val(val_x)
   );

   crm_lane #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_lane_y (
      .clock(clock), .cmd(cmd), .w0(wy_ff[0]), .w1(wy_ff[1]), .w2(wy_ff[2]),
      .q(qy_ff), .s_eff(s_eff), .s2(s2_ff), .s3(s3_ff), .k(k_ff), .val(val_y)
   );

   // Curve points: first of a span goes to prev, later ones to cur
   always_ff @(posedge clock) begin
      if (cmd.op == crm_pkg::OP_STORE) begin
         if (k_ff == '0) begin
            prev_x_ff <= val_x;
            prev_y_ff <= val_y;
         end else begin
            cur_x_ff <= val_x;
            cur_y_ff <= val_y;
         end
      end
      if (cmd.out_load) begin
         out_x1_ff   <= prev_x_ff;
         out_y1_ff   <= prev_y_ff;
         out_x2_ff   <= cur_x_ff;
         out_y2_ff   <= cur_y_ff;
         out_last_ff <= cmd.out_last;
         prev_x_ff   <= cur_x_ff;
         prev_y_ff   <= cur_y_ff;
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.div_done = (div_cnt_ff == DCW'(Q_W - 1));
   assign status.k_zero   = (k_ff == '0);
   assign status.k_end    = (k_ff == s_eff);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_valid   = out_valid_ff;
   assign seg_x1      = out_x1_ff;
   assign seg_y1      = out_y1_ff;
   assign seg_x2      = out_x2_ff;
   assign seg_y2      = out_y2_ff;
   assign last_of_run = out_last_ff;

endmodule

// ===== hw/rtl/crm_ctrl.sv =====
// Controller: sequences spans, evaluations, divisions and segment transfers.
module crm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  crm_pkg::dp_status_type status,
   output crm_pkg::dp_cmd_type    cmd
);

   crm_pkg::ctrl_state_type state_ff, state_in;
   crm_pkg::span_kind_type  kind_ff, kind_in;
   logic [1:0]              seen_ff, seen_in;
   logic                    last_ff, last_in;
   logic                    second_ff, second_in;
   logic                    accept;

   // Input taken only in idle and never while reset is held
   assign req_ready = (state_ff == crm_pkg::ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= crm_pkg::ST_IDLE;
         kind_ff   <= crm_pkg::SPAN_AAQQ;
         seen_ff   <= 2'd0;
         last_ff   <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         seen_ff   <= seen_in;
         last_ff   <= last_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      seen_in      = seen_ff;
      last_in      = last_ff;
      second_in    = second_ff;
      cmd          = '0;
      cmd.op       = crm_pkg::OP_NOP;
      cmd.kind     = kind_ff;
      cmd.win      = crm_pkg::WIN_NONE;
      unique case (state_ff)
         crm_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               last_in     = req_last;
               second_in   = req_last && (seen_ff >= 2'd2);
               unique case (seen_ff)
                  2'd1:    kind_in = crm_pkg::SPAN_AAQQ;
                  2'd2:    kind_in = crm_pkg::SPAN_AABQ;
                  default: kind_in = crm_pkg::SPAN_ABCQ;
               endcase
               if (seen_ff >= 2'd2 || (seen_ff == 2'd1 && req_last)) begin
                  state_in = crm_pkg::ST_LOAD;
               end else begin
                  state_in = crm_pkg::ST_WIN;
               end
            end
         end
         crm_pkg::ST_LOAD: begin
            cmd.op      = crm_pkg::OP_LOAD;
            cmd.k_clear = 1'b1;
            state_in    = crm_pkg::ST_S2;
         end
         crm_pkg::ST_S2: begin
            cmd.op   = crm_pkg::OP_S2;
            state_in = crm_pkg::ST_S3;
         end
         crm_pkg::ST_S3: begin
            cmd.op   = crm_pkg::OP_S3;
            state_in = crm_pkg::ST_CS;
         end
         crm_pkg::ST_CS: begin
            cmd.op   = crm_pkg::OP_CS;
            state_in = crm_pkg::ST_BS;
         end
         crm_pkg::ST_BS: begin
            cmd.op   = crm_pkg::OP_BS;
            state_in = crm_pkg::ST_PS;
         end
         crm_pkg::ST_PS: begin
            cmd.op   = crm_pkg::OP_PS;
            state_in = crm_pkg::ST_H0;
         end
         crm_pkg::ST_H0: begin
            cmd.op   = crm_pkg::OP_H0;
            state_in = crm_pkg::ST_H1;
         end
         crm_pkg::ST_H1: begin
            cmd.op   = crm_pkg::OP_H1;
            state_in = crm_pkg::ST_H2;
         end
         crm_pkg::ST_H2: begin
            cmd.op   = crm_pkg::OP_H2;
            state_in = crm_pkg::ST_DINIT;
         end
         crm_pkg::ST_DINIT: begin
            cmd.op   = crm_pkg::OP_DINIT;
            state_in = crm_pkg::ST_DSTEP;
         end
         crm_pkg::ST_DSTEP: begin
            cmd.op = crm_pkg::OP_DSTEP;
            if (status.div_done) begin
               state_in = crm_pkg::ST_STORE;
            end
         end
         crm_pkg::ST_STORE: begin
            cmd.op = crm_pkg::OP_STORE;
            if (status.k_zero) begin
               cmd.k_inc = 1'b1;
               state_in  = crm_pkg::ST_H0;
            end else begin
               state_in = crm_pkg::ST_EMIT;
            end
         end
         crm_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = status.k_end && !second_ff;
               if (!status.k_end) begin
                  cmd.k_inc = 1'b1;
                  state_in  = crm_pkg::ST_H0;
               end else if (second_ff) begin
                  second_in = 1'b0;
                  kind_in   = (seen_ff == 2'd2) ? crm_pkg::SPAN_ABQQ : crm_pkg::SPAN_BCQQ;
                  state_in  = crm_pkg::ST_LOAD;
               end else begin
                  state_in = crm_pkg::ST_WIN;
               end
            end
         end
         crm_pkg::ST_WIN: begin
            unique case (seen_ff)
               2'd0:    cmd.win = crm_pkg::WIN_SET0;
               2'd1:    cmd.win = crm_pkg::WIN_SET1;
               2'd2:    cmd.win = crm_pkg::WIN_SET2;
               default: cmd.win = crm_pkg::WIN_SHIFT;
            endcase
            if (last_ff) begin
               seen_in = 2'd0;
            end else if (seen_ff != 2'd3) begin
               seen_in = seen_ff + 2'd1;
            end
            state_in = crm_pkg::ST_IDLE;
         end
         default: state_in = crm_pkg::ST_IDLE;
      endcase
   end

   // A finished quotient is always stored next
   a_div_to_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crm_pkg::ST_DSTEP && status.div_done) |=> state_ff == crm_pkg::ST_STORE)
      else $error("divider finished without store");

   // The first curve point of a span never produces a segment
   a_first_no_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crm_pkg::ST_STORE && status.k_zero) |=> state_ff == crm_pkg::ST_H0)
      else $error("first span point went to emit");

   // Never overwrite a segment that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten");

endmodule

// ===== hw/rtl/catmull_rom_segment_generator.sv =====
// Top level: uniform Catmull-Rom segment generator, stream in, segments out.
// A point that closes no span is accepted, then updates the window, before the next is taken.
// A span runs setup (load, S^2, S^3, coefficient products), then S+1 evaluations (3 Horner
// steps, divider init, COORD_BITS+3 divide steps, store) and one transfer per segment, which
// waits while the output register holds an untaken segment; divide steps dominate the span.
// Synchronous active-high reset clears control, the window count and S to 16.
module catmull_rom_segment_generator #(
   parameter int MAX_STEPS  = crm_pkg::DEF_MAX_STEPS,
   parameter int COORD_BITS = crm_pkg::DEF_COORD_BITS,
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_W-1:0]            req_tdata,  // point_x, point_y, zero pad
   input  logic                        req_tlast,  // last_point
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [crm_pkg::RSP_W-1:0]   rsp_tdata,  // seg_x1, seg_y1, seg_x2, seg_y2, pad
   output logic                        rsp_tlast,  // last_of_run
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [crm_pkg::CFG_W-1:0]   csr_data    // steps_per_span
);

   localparam int OB = crm_pkg::OUT_BITS;

   crm_pkg::dp_cmd_type    cmd;
   crm_pkg::dp_status_type status;
   logic signed [OB-1:0]   seg_x1, seg_y1, seg_x2, seg_y2;

   // Register writes taken whenever reset is released
   assign csr_ready = !reset;

   crm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_tvalid), .req_last(req_tlast),
      .req_ready(req_tready), .status(status), .cmd(cmd)
   );

   crm_datapath #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_x($signed(req_tdata[COORD_BITS-1:0])),
      .in_y($signed(req_tdata[2*COORD_BITS-1:COORD_BITS])),
      .csr_valid(csr_valid && csr_ready), .csr_data(csr_data),
      .rsp_tready(rsp_tready), .status(status), .rsp_valid(rsp_tvalid),
      .seg_x1(seg_x1), .seg_y1(seg_y1), .seg_x2(seg_x2), .seg_y2(seg_y2),
      .last_of_run(rsp_tlast)
   );

   // Pack result fields, lowest field first
   assign rsp_tdata = {{(crm_pkg::RSP_W - 4 * OB){1'b0}}, seg_y2, seg_x2, seg_y1, seg_x1};

endmodule
